// ----- hw/rtl/sprite_animation_sequencer_assert.svh -----
// Assertion macros for the sprite animation sequencer checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SPRITE_ANIMATION_SEQUENCER_ASSERT_SVH
`define SPRITE_ANIMATION_SEQUENCER_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define SAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while in reset.
`define SAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sas_pkg.sv -----
// Shared constants, payload types and helpers for the sprite animation sequencer.
// No dependencies.
package sas_pkg;

    localparam int ANIM_SLOTS  = 16;
    localparam int MAX_COLUMNS = 16;
    localparam int TIME_BITS   = 16;

    localparam int ID_W       = 4;
    localparam int ADDR_W     = $clog2(ANIM_SLOTS);
    localparam int FC_W       = 9;
    localparam int CELL_W     = FC_W + 1;
    localparam int COL_W      = $clog2(MAX_COLUMNS + 1);
    localparam int ACC_W      = TIME_BITS + 1;
    localparam int Q_W        = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [Q_W-1:0] Q_ONE = 17'h10000;

    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_ADD  = 2'd1;
    localparam logic [1:0] MODE_PLAY = 2'd2;
    localparam logic [1:0] MODE_IDLE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO_ID = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_W  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT  = 3'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] elapsed_ticks;
        logic [3:0]  anim_id;
        logic [8:0]  first_cell;
        logic [8:0]  frame_total;
        logic [15:0] frame_delay_ticks;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        frame_changed;
        logic [3:0]  cell_column;
        logic [7:0]  cell_row;
        logic [16:0] u_left;
        logic [16:0] u_right;
        logic [16:0] v_low;
        logic [16:0] v_high;
        logic [3:0]  playing_id;
        logic [7:0]  frame_number;
        logic        idle_flag;
    } result_t;

    typedef struct packed {
        logic [FC_W-1:0]      first_cell;
        logic [FC_W-1:0]      frame_total;
        logic [TIME_BITS-1:0] delay;
    } entry_t;

    typedef struct packed {
        logic [CELL_W-1:0] quot;
        logic [COL_W-1:0]  rem;
    } div_res_t;

    typedef struct packed {
        logic [Q_W-1:0] u_left;
        logic [Q_W-1:0] u_right;
        logic [Q_W-1:0] v_low;
        logic [Q_W-1:0] v_high;
    } tex_t;

    function automatic logic [ADDR_W-1:0] id_addr(input logic [ID_W-1:0] id);
        logic [7:0] ext;
        ext = 8'(id);
        return ext[ADDR_W-1:0];
    endfunction

    // Fit a 16-bit time field to the time width.
    function automatic logic [TIME_BITS-1:0] time_fit(input logic [15:0] t);
        logic [31:0] ext;
        ext = 32'(t);
        return ext[TIME_BITS-1:0];
    endfunction

endpackage

// ----- hw/rtl/sas_channels.sv -----
// Valid/ready channel interfaces: item input, result output, register writes.
// Depends on sas_pkg.
interface sas_item_if;
    import sas_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sas_result_if;
    import sas_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sas_cfg_if;
    import sas_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- hw/rtl/sas_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/sas_celldiv.sv -----
// Bit-serial restoring divider: sheet cell index by column count.
// Depends on sas_pkg.
module sas_celldiv (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [sas_pkg::CELL_W-1:0] dividend,
    input  logic [sas_pkg::COL_W-1:0]  divisor,
    output logic                      done,
    output sas_pkg::div_res_t         res
);
    import sas_pkg::*;

    localparam int CNT_W = $clog2(CELL_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CELL_W-1:0] quo_reg;
    logic [COL_W-1:0]  rem_reg;
    logic [COL_W-1:0]  dsr_reg;

    logic [COL_W:0]    shifted;
    logic [COL_W:0]    diff;
    logic              fits;
    logic [COL_W-1:0]  rem_next;
    logic [CELL_W-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[CELL_W-1]};
        fits     = shifted >= {1'b0, dsr_reg};
        diff     = shifted - {1'b0, dsr_reg};
        rem_next = fits ? diff[COL_W-1:0] : shifted[COL_W-1:0];
        quo_next = {quo_reg[CELL_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                cnt_reg  <= CNT_W'(CELL_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

endmodule

// ----- hw/rtl/sas_texmap.sv -----
// Texture bounds of one sheet cell: registered products, then Q1.16 saturation.
// Depends on sas_pkg.
module sas_texmap (
    input  logic                       clk,
    input  logic                       load,
    input  logic [sas_pkg::COL_W-1:0]  col,
    input  logic [sas_pkg::CELL_W-1:0] row,
    input  logic [sas_pkg::Q_W-1:0]    cell_w,
    input  logic [sas_pkg::Q_W-1:0]    cell_h,
    output sas_pkg::tex_t              tex
);
    import sas_pkg::*;

    localparam int PU_W = COL_W + Q_W;
    localparam int PV_W = CELL_W + 1 + Q_W;

    logic [PU_W-1:0] ul_reg, ur_reg;
    logic [PV_W-1:0] vh_reg, vl_reg;

    logic [COL_W-1:0]  col_inc;
    logic [CELL_W:0]   row_inc;

    function automatic logic [Q_W-1:0] sat_u(input logic [PU_W-1:0] p);
        return (p > PU_W'(Q_ONE)) ? Q_ONE : p[Q_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] one_minus(input logic [PV_W-1:0] p);
        return (p >= PV_W'(Q_ONE)) ? '0 : Q_ONE - p[Q_W-1:0];
    endfunction

    always_comb
    begin
        // col stays below the column count, so col + 1 fits
        col_inc = col + 1'b1;
        row_inc = {1'b0, row} + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ul_reg <= PU_W'(col) * PU_W'(cell_w);
            ur_reg <= PU_W'(col_inc) * PU_W'(cell_w);
            vh_reg <= PV_W'(row) * PV_W'(cell_h);
            vl_reg <= PV_W'(row_inc) * PV_W'(cell_h);
        end
    end

    always_comb
    begin
        tex.u_left  = sat_u(ul_reg);
        tex.u_right = sat_u(ur_reg);
        tex.v_low   = one_minus(vl_reg);
        tex.v_high  = one_minus(vh_reg);
    end

endmodule

// ----- hw/rtl/sprite_animation_sequencer.sv -----
// Channel   | Dir | Carries
// ----------+-----+-------------------------------------------------------
// item      | in  | one operation per beat: tick, add, play, set idle
// result    | out | status, frame change with cell and texture bounds, state
// cfg       | in  | register index and write data, always ready
//
// A beat without a frame change goes through S_EXEC and S_OUT into the output
// register once accepted; a frame change adds the bit-serial cell divider (one
// quotient bit per cycle) and the product stage. The next item is taken the cycle
// after the result register loads. A stalled result holds the next item in S_OUT.
// The animation table sits in one synchronous RAM: read on accept, written
// back in the execute cycle, so no two items touch it at once.
// Reset clears the valid bits and scalar state at once; there is no clearing pass.
// The output register holds one result; the next item is taken while it waits.
// Depends on sas_pkg, sas_channels, sas_ram, sas_celldiv, sas_texmap.
module sprite_animation_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    sas_item_if.sink      item,
    sas_result_if.source  result,
    sas_cfg_if.sink       cfg
);
    import sas_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_OUT
    } state_t;

    localparam int SUM_W = ACC_W + 1;

    state_t                state_reg, state_next;
    item_t                 item_reg, item_next;
    logic [ANIM_SLOTS-1:0] valid_reg, valid_next;
    logic [ID_W-1:0]       cur_reg, cur_next;
    logic [ID_W-1:0]       idle_reg, idle_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [FC_W-1:0]       fc_reg, fc_next;
    logic                  ids_reg, ids_next;
    result_t               pend_reg, pend_next;
    logic                  draw_reg, draw_next;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_data_reg, out_data_next;
    logic [4:0]            columns_reg, columns_next;
    logic [Q_W-1:0]        cell_w_reg, cell_w_next;
    logic [Q_W-1:0]        cell_h_reg, cell_h_next;
    logic                  repeat_reg, repeat_next;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    entry_t                ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;

    logic                  div_start;
    logic [CELL_W-1:0]     div_dividend;
    logic [COL_W-1:0]      cols;
    logic                  div_done;
    div_res_t              div_res;
    logic                  tex_load;
    tex_t                  tex;

    sas_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ANIM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sas_celldiv u_celldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cols),
        .done     (div_done),
        .res      (div_res)
    );

    sas_texmap u_texmap (
        .clk    (clk),
        .load   (tex_load),
        .col    (div_res.rem),
        .row    (div_res.quot),
        .cell_w (cell_w_reg),
        .cell_h (cell_h_reg),
        .tex    (tex)
    );

    assign item.ready   = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // Read the record a tick will use, or the one named by the item.
    always_comb
    begin
        if (item.data.mode == MODE_TICK)
        begin
            ram_raddr = id_addr((cur_reg == '0) ? idle_reg : cur_reg);
        end
        else
        begin
            ram_raddr = id_addr(item.data.anim_id);
        end
    end

    always_comb
    begin
        if (columns_reg == '0)
        begin
            cols = COL_W'(1);
        end
        else if (32'(columns_reg) > MAX_COLUMNS)
        begin
            cols = COL_W'(MAX_COLUMNS);
        end
        else
        begin
            cols = COL_W'(columns_reg);
        end
    end

    always_comb
    begin
        entry_t            ent;
        logic [ADDR_W-1:0] addr;
        logic              in_range;
        logic              known;
        logic              early;
        logic [SUM_W-1:0]  acc_sum;
        logic [CELL_W-1:0] cell_sum;
        result_t           res;

        ent      = entry_t'(ram_rdata);
        addr     = id_addr(item_reg.anim_id);
        in_range = 32'(item_reg.anim_id) < ANIM_SLOTS;
        known    = (item_reg.anim_id != '0) && in_range && valid_reg[addr];
        early    = 1'b0;
        acc_sum  = '0;
        cell_sum = '0;
        res      = pend_reg;

        state_next     = state_reg;
        item_next      = item_reg;
        valid_next     = valid_reg;
        cur_next       = cur_reg;
        idle_next      = idle_reg;
        acc_next       = acc_reg;
        fc_next        = fc_reg;
        ids_next       = ids_reg;
        pend_next      = pend_reg;
        draw_next      = draw_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        columns_next   = columns_reg;
        cell_w_next    = cell_w_reg;
        cell_h_next    = cell_h_reg;
        repeat_next    = repeat_reg;

        ram_we                = 1'b0;
        ram_waddr             = addr;
        ram_wdata.first_cell  = item_reg.first_cell;
        ram_wdata.frame_total = item_reg.frame_total;
        ram_wdata.delay       = time_fit(item_reg.frame_delay_ticks);
        div_start             = 1'b0;
        div_dividend          = '0;
        tex_load              = 1'b0;

        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_COLUMNS: columns_next = cfg.wdata[4:0];
                REG_CELL_W:  cell_w_next  = cfg.wdata;
                REG_CELL_H:  cell_h_next  = cfg.wdata;
                REG_REPEAT:  repeat_next  = cfg.wdata[0];
                default:     ;
            endcase
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    item_next  = item.data;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                pend_next        = '0;
                pend_next.status = ST_OK;
                draw_next        = 1'b0;
                unique case (item_reg.mode)
                    MODE_TICK:
                    begin
                        if (cur_reg == '0)
                        begin
                            ids_next = 1'b1;
                            if (idle_reg == '0)
                            begin
                                early = 1'b1;
                            end
                            else
                            begin
                                draw_next = 1'b1;
                                cur_next  = idle_reg;
                            end
                        end
                        if (!early)
                        begin
                            acc_sum  = {1'b0, acc_reg}
                                     + SUM_W'(time_fit(item_reg.elapsed_ticks));
                            // saturate the accumulator
                            acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
                            if (acc_next >= ACC_W'(ent.delay))
                            begin
                                draw_next = 1'b1;
                                acc_next  = acc_next - ACC_W'(ent.delay);
                                fc_next   = fc_reg + 1'b1;
                                if (fc_next >= ent.frame_total)
                                begin
                                    fc_next = '0;
                                    if (!repeat_reg)
                                    begin
                                        ids_next = 1'b1;
                                        cur_next = idle_reg;
                                        if (idle_reg == '0)
                                        begin
                                            acc_next  = '0;
                                            draw_next = 1'b0;
                                        end
                                    end
                                end
                            end
                        end
                    end

                    MODE_ADD:
                    begin
                        if (item_reg.anim_id == '0)
                        begin
                            pend_next.status = ST_ZERO_ID;
                        end
                        else if (!in_range)
                        begin
                            pend_next.status = ST_UNKNOWN;
                        end
                        else if (!valid_reg[addr])
                        begin
                            ram_we           = 1'b1;
                            valid_next[addr] = 1'b1;
                        end
                    end

                    MODE_PLAY:
                    begin
                        if (!known)
                        begin
                            pend_next.status = ST_UNKNOWN;
                        end
                        else
                        begin
                            cur_next  = item_reg.anim_id;
                            fc_next   = '0;
                            acc_next  = '0;
                            ids_next  = 1'b0;
                            draw_next = 1'b1;
                        end
                    end

                    MODE_IDLE:
                    begin
                        if (!known)
                        begin
                            pend_next.status = ST_UNKNOWN;
                        end
                        else
                        begin
                            idle_next = item_reg.anim_id;
                            if (ids_reg && (cur_reg != item_reg.anim_id))
                            begin
                                cur_next  = item_reg.anim_id;
                                fc_next   = '0;
                                acc_next  = '0;
                                draw_next = 1'b1;
                            end
                        end
                    end
                endcase

                pend_next.playing_id   = cur_next;
                pend_next.frame_number = fc_next[7:0];
                pend_next.idle_flag    = ids_next;

                // Draw from the record just read, even on a fallback to idle.
                cell_sum     = {1'b0, ent.first_cell} + {1'b0, fc_next};
                div_dividend = (cell_sum == '0) ? '0 : cell_sum - 1'b1;

                if (draw_next)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    tex_load   = 1'b1;
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (draw_reg)
                begin
                    res.frame_changed = 1'b1;
                    res.cell_column   = 4'(div_res.rem);
                    res.cell_row      = (div_res.quot > CELL_W'(255)) ? 8'hFF
                                                                      : div_res.quot[7:0];
                    res.u_left        = tex.u_left;
                    res.u_right       = tex.u_right;
                    res.v_low         = tex.v_low;
                    res.v_high        = tex.v_high;
                end
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            valid_reg     <= '0;
            cur_reg       <= '0;
            idle_reg      <= '0;
            acc_reg       <= '0;
            fc_reg        <= '0;
            ids_reg       <= 1'b0;
            pend_reg      <= '0;
            draw_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            columns_reg   <= 5'd1;
            cell_w_reg    <= Q_ONE;
            cell_h_reg    <= Q_ONE;
            repeat_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            valid_reg     <= valid_next;
            cur_reg       <= cur_next;
            idle_reg      <= idle_next;
            acc_reg       <= acc_next;
            fc_reg        <= fc_next;
            ids_reg       <= ids_next;
            pend_reg      <= pend_next;
            draw_reg      <= draw_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            columns_reg   <= columns_next;
            cell_w_reg    <= cell_w_next;
            cell_h_reg    <= cell_h_next;
            repeat_reg    <= repeat_next;
        end
    end

endmodule

// ----- hw/rtl/sas_checker.sv -----
// Port-level checks for the sprite animation sequencer, bound to the top level.
// Depends on sas_pkg and sprite_animation_sequencer_assert.svh.
`include "sprite_animation_sequencer_assert.svh"

module sas_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input logic             result_valid,
    input logic             result_ready,
    input sas_pkg::result_t result_data
);
    import sas_pkg::*;

    `SAS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data), "stalled result beat changed")
    `SAS_ASSERT_NEXT(a_one_at_a_time, item_valid && item_ready, !item_ready, "item taken while one is in flight")
    `SAS_ASSERT_NOW(a_error_no_draw, result_valid && (result_data.status != ST_OK), !result_data.frame_changed, "error beat reports a frame change")
    `SAS_ASSERT_NOW(a_no_draw_zero, result_valid && !result_data.frame_changed, (result_data.cell_column == '0) && (result_data.cell_row == '0) && (result_data.u_left == '0) && (result_data.u_right == '0) && (result_data.v_low == '0) && (result_data.v_high == '0), "cell fields set without a frame change")
    `SAS_ASSERT_NOW(a_bounds_order, result_valid && result_data.frame_changed, (result_data.u_left <= result_data.u_right) && (result_data.v_low <= result_data.v_high) && (result_data.u_right <= Q_ONE) && (result_data.v_high <= Q_ONE), "texture bounds out of order or range")

endmodule

bind sprite_animation_sequencer sas_checker u_sas_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
